// ----- hw/rtl/bpdb_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded priority deque bank package
// Shared payload types, status and command codes and default sizes.
// ----------------------------------------------------------------------------
package bpdb_pkg;

  localparam int unsigned NUM_QUEUES_DEF  = 20;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned SLOT_W  = ID_W + 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  localparam logic [2:0] ST_ADDED  = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_SERVED = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_BADIDX = 3'd4;

  typedef struct packed {
    logic            cmd;
    logic [4:0]      queue_index;
    logic            urgent;
    logic [ID_W-1:0] entry_id;
  } bpdb_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [ID_W-1:0] served_id;
    logic            served_urgent;
    logic [3:0]      occupancy;
  } bpdb_out_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic load;
  } bpdb_ram_ctl_t;

endpackage

// ----- hw/rtl/bpdb_slot_ram.sv -----
// ----------------------------------------------------------------------------
// Slot storage RAM
// Single-port storage for all queue slots with a registered read that
// clears to zero when a result is loaded without a read.
// ----------------------------------------------------------------------------
module bpdb_slot_ram #(
  parameter int unsigned DEPTH  = 160,
  parameter int unsigned ADDR_W = 8
) (
  input  logic                          clk,
  input  bpdb_pkg::bpdb_ram_ctl_t       ctl,
  input  logic [ADDR_W-1:0]             addr,
  input  logic [bpdb_pkg::SLOT_W-1:0]   wr_data,
  output logic [bpdb_pkg::SLOT_W-1:0]   rd_data
);
  import bpdb_pkg::*;

  logic [SLOT_W-1:0] mem [DEPTH];
  logic [SLOT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.rd_en) begin
        rd_data_r <= mem[addr];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/bounded_priority_deque_bank_core.sv -----
// ----------------------------------------------------------------------------
// Bounded priority deque bank
// A bank of bounded deques with urgent insertion at the front.
// ----------------------------------------------------------------------------
// Each input transfer carries an add or a take for one queue. An add places
// its entry at the front (urgent) or back of the queue while the queue holds
// fewer entries than the configured limit capped at the queue depth; a take
// removes the front entry. Every input transfer produces exactly one result
// transfer. The input item is registered, processed against the per-queue
// head and count registers and the slot RAM, and the result is presented
// from the result register and the registered slot RAM read.
// Throughput is one item per cycle unless the receiver stalls: head, count and
// one slot update with each processed item, so the next item needs no stall.
// When the receiver stalls, the result holds and one more item can wait in
// the input register before in_ready drops.
// Reset clears all heads, counts and valid flags and sets the limit to five;
// slot contents are not cleared and are only read after being written.
// The user must write the limit register via cfg_wr_en only while idle; unchecked.
// ----------------------------------------------------------------------------
module bounded_priority_deque_bank_core #(
  parameter int unsigned NUM_QUEUES  = bpdb_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH = bpdb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bpdb_pkg::bpdb_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bpdb_pkg::bpdb_out_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [bpdb_pkg::LIMIT_W-1:0]   cfg_wr_data
);
  import bpdb_pkg::*;

  localparam int unsigned QI_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned HD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned MEM_D  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;

  logic [LIMIT_W-1:0] limit_r;
  bpdb_in_t           item_r;
  logic               item_valid_r;
  logic               out_valid_r;
  logic [2:0]         status_r;
  logic [3:0]         occ_r;
  logic [HD_W-1:0]    head_r  [NUM_QUEUES];
  logic [CNT_W-1:0]   count_r [NUM_QUEUES];

  logic               advance;
  logic               proc;
  logic               bad;
  logic [QI_W-1:0]    qi;
  logic [HD_W-1:0]    hd;
  logic [CNT_W-1:0]   cnt;
  logic [7:0]         lim_eff;
  logic               room;
  logic [HD_W-1:0]    hd_dec;
  logic [HD_W-1:0]    hd_inc;
  logic [SUM_W-1:0]   tail_sum;
  logic [HD_W-1:0]    tail;
  logic [HD_W-1:0]    slot;
  logic [2:0]         status_nxt;
  logic [CNT_W-1:0]   count_nxt;
  logic [HD_W-1:0]    head_nxt;
  logic [3:0]         occ_nxt;
  logic               upd;
  bpdb_ram_ctl_t      ram_ctl;
  logic [ADDR_W-1:0]  ram_addr;
  logic [SLOT_W-1:0]  ram_rd_data;

  assign advance  = !out_valid_r || out_ready;
  assign proc     = item_valid_r && advance;
  assign in_ready = !item_valid_r || advance;

  assign bad = {1'b0, item_r.queue_index} >= 6'(NUM_QUEUES);
  assign qi  = item_r.queue_index[QI_W-1:0];
  assign hd  = head_r[qi];
  assign cnt = count_r[qi];

  assign lim_eff = (8'(limit_r) > 8'(QUEUE_DEPTH)) ? 8'(QUEUE_DEPTH) : 8'(limit_r);
  assign room    = 8'(cnt) < lim_eff;

  assign hd_dec   = (hd == '0) ? HD_W'(QUEUE_DEPTH - 1) : hd - 1'b1;
  assign hd_inc   = (hd == HD_W'(QUEUE_DEPTH - 1)) ? '0 : hd + 1'b1;
  assign tail_sum = SUM_W'(hd) + SUM_W'(cnt);
  assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    HD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HD_W'(tail_sum);

  always_comb begin
    status_nxt    = ST_BADIDX;
    count_nxt     = cnt;
    head_nxt      = hd;
    occ_nxt       = '0;
    upd           = 1'b0;
    slot          = hd;
    ram_ctl.wr_en = 1'b0;
    ram_ctl.rd_en = 1'b0;
    ram_ctl.load  = proc;
    priority if (bad) begin
      status_nxt = ST_BADIDX;
    end else if (item_r.cmd == CMD_ADD) begin
      if (room) begin
        status_nxt    = ST_ADDED;
        count_nxt     = cnt + 1'b1;
        upd           = 1'b1;
        ram_ctl.wr_en = proc;
        if (item_r.urgent) begin
          head_nxt = hd_dec;
          slot     = hd_dec;
        end else begin
          slot = tail;
        end
      end else begin
        status_nxt = ST_FULL;
      end
      occ_nxt = 4'(count_nxt);
    end else begin
      if (cnt != '0) begin
        status_nxt    = ST_SERVED;
        count_nxt     = cnt - 1'b1;
        head_nxt      = hd_inc;
        upd           = 1'b1;
        ram_ctl.rd_en = proc;
        occ_nxt       = 4'(count_nxt);
      end else begin
        status_nxt = ST_EMPTY;
      end
    end
  end

  assign ram_addr = ADDR_W'(qi) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid_r <= 1'b1;
      end else if (proc) begin
        item_valid_r <= 1'b0;
      end
      if (proc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (proc) begin
      status_r <= status_nxt;
      occ_r    <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (proc && upd) begin
      head_r[qi]  <= head_nxt;
      count_r[qi] <= count_nxt;
    end
  end

  bpdb_slot_ram #(
    .DEPTH  (MEM_D),
    .ADDR_W (ADDR_W)
  ) u_slot_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .addr    (ram_addr),
    .wr_data ({item_r.urgent, item_r.entry_id}),
    .rd_data (ram_rd_data)
  );

  assign out_valid              = out_valid_r;
  assign out_data.status        = status_r;
  assign out_data.served_id     = ram_rd_data[ID_W-1:0];
  assign out_data.served_urgent = ram_rd_data[ID_W];
  assign out_data.occupancy     = occ_r;

endmodule

// ----- hw/rtl/bpdb_checker.sv -----
// ----------------------------------------------------------------------------
// Bounded priority deque bank checker
// Port-level assertions on result transfers, attached to the core by bind.
// ----------------------------------------------------------------------------
module bpdb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input bpdb_pkg::bpdb_out_t            out_data
);
  import bpdb_pkg::*;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or dropped.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_BADIDX |->
      out_data.served_id == '0 && !out_data.served_urgent && out_data.occupancy == '0)
    else $error("Bad index result carries data.");

  a_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_ADDED || out_data.status == ST_FULL) |->
      out_data.served_id == '0 && !out_data.served_urgent)
    else $error("Add result carries a served entry.");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.served_id == '0 && !out_data.served_urgent && out_data.occupancy == '0)
    else $error("Empty take result carries data.");

endmodule

bind bounded_priority_deque_bank_core bpdb_checker u_bpdb_checker (.*);
